// ----- design/smi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_pkg
// Shared types and constants of the small matrix inverse unit.
// ----------------------------------------------------------------------------
package smi_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int ELEM_W      = 32;
   localparam int ADJ_W       = 64;                 // adjugate entry, signed
   localparam int DET_W       = 97;                 // determinant, signed
   localparam int MAG_W       = DET_W - 1;          // determinant magnitude
   localparam int NUM_W       = MAG_W + 2;          // 2*|adj|<<2F + |det|
   localparam int DEN_W       = MAG_W + 1;          // 2*|det|
   localparam int QUO_W       = ELEM_W + 1;         // rounded quotient bits
   localparam int CMP_W       = DEN_W + QUO_W;
   localparam int LANE_LAT    = QUO_W + 1;          // overflow check + bits
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int THR_W       = 31;

   localparam logic [ELEM_W-1:0] ONE_FIX = ELEM_W'(1) << FRAC_BITS;
   localparam logic [ELEM_W-1:0] POS_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [ELEM_W-1:0] NEG_MAX = {1'b1, {(ELEM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_SINGULAR = 2'd1,
      STAT_ZERO     = 2'd2,
      STAT_SAT      = 2'd3
   } smi_status_type;

   // classified matrix handed from front end to back end
   typedef struct packed {
      logic [1:0]                order;
      logic [8:0][ADJ_W-1:0]     adj;
      logic [DET_W-1:0]          det;
   } smi_item_type;

   typedef struct packed {
      logic         valid;
      smi_item_type item;
   } smi_push_type;

   // per-item control riding alongside the divider lanes
   typedef struct packed {
      logic              valid;
      logic [1:0]        order;
      logic [8:0]        neg;
      logic [ELEM_W-1:0] det_value;
      logic              det_sat;
      logic              zero_scalar;
      logic              singular;
   } smi_side_type;

endpackage

// ----- design/smi_div_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_div_lane
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module smi_div_lane (
   input  logic                     clock,
   input  logic [smi_pkg::NUM_W-1:0] num,
   input  logic [smi_pkg::DEN_W-1:0] den,
   output logic [smi_pkg::QUO_W-1:0] quo,
   output logic                     ovf
);
   import smi_pkg::*;

   logic [NUM_W-1:0] r_ff   [0:QUO_W];
   logic [DEN_W-1:0] den_ff [0:QUO_W];
   logic [QUO_W-1:0] q_ff   [0:QUO_W];
   logic             ovf_ff [0:QUO_W];

   // quotient does not fit in QUO_W bits
   always_ff @(posedge clock) begin
      r_ff[0]   <= num;
      den_ff[0] <= den;
      q_ff[0]   <= '0;
      ovf_ff[0] <= CMP_W'(num) >= {den, {QUO_W{1'b0}}};
   end

   for (genvar s = 1; s <= QUO_W; s++) begin : g_step
      logic [CMP_W-1:0] rem_ext;
      logic [CMP_W-1:0] den_sh;
      logic             ge;

      always_comb begin
         rem_ext = CMP_W'(r_ff[s-1]);
         den_sh  = CMP_W'(den_ff[s-1]) << (QUO_W - s);
         ge      = rem_ext >= den_sh;
      end

      always_ff @(posedge clock) begin
         r_ff[s]   <= ge ? NUM_W'(rem_ext - den_sh) : r_ff[s-1];
         den_ff[s] <= den_ff[s-1];
         q_ff[s]   <= {q_ff[s-1][QUO_W-2:0], ge};
         ovf_ff[s] <= ovf_ff[s-1];
      end
   end

   assign quo = q_ff[QUO_W];
   assign ovf = ovf_ff[QUO_W];

endmodule

// ----- design/smi_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_front
// Captures requests, forms the adjugate and the determinant in five stages.
// ----------------------------------------------------------------------------
module smi_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [1:0]                      size,
   input  logic [8:0][smi_pkg::ELEM_W-1:0] elem,
   output smi_pkg::smi_push_type           push
);
   import smi_pkg::*;

   // stage 1: captured matrix
   logic                   v1_ff;
   logic [1:0]             ord1_ff;
   logic [8:0][ELEM_W-1:0] m1_ff;
   // stage 2: minor products
   logic                   v2_ff;
   logic [1:0]             ord2_ff;
   logic [8:0][ELEM_W-1:0] m2_ff;
   logic [8:0][ADJ_W-1:0]  p1_ff, p2_ff, p1_in, p2_in;
   // stage 3: adjugate
   logic                   v3_ff;
   logic [1:0]             ord3_ff;
   logic [8:0][ADJ_W-1:0]  adj3_ff, adj3_in, cof;
   logic [2:0][ADJ_W-1:0]  col3_ff;
   logic [2:0][ELEM_W-1:0] mc3_ff;
   logic [ADJ_W-1:0]       det2_3_ff;
   // stage 4: partial products of the first-column expansion
   logic                   v4_ff;
   logic [1:0]             ord4_ff;
   logic [8:0][ADJ_W-1:0]  adj4_ff;
   logic [ADJ_W-1:0]       det2_4_ff;
   logic [ELEM_W-1:0]      m00_4_ff;
   logic [2:0][ADJ_W:0]    lo_ff, lo_in;
   logic [2:0][ADJ_W-1:0]  hi_ff, hi_in;
   // stage 5: determinant
   logic                   v5_ff;
   smi_item_type           item5_ff;
   logic [DET_W-1:0]       det_in;
   logic [1:0]             ord_in;

   assign ord_in = (size == 2'd0) ? 2'd1 : size;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            int r1, r2, c1, c2;
            r1 = (i == 2) ? 0 : i + 1;
            r2 = (i == 0) ? 2 : i - 1;
            c1 = (j == 2) ? 0 : j + 1;
            c2 = (j == 0) ? 2 : j - 1;
            p1_in[i*3+j] = $signed(m1_ff[r1*3+c1]) * $signed(m1_ff[r2*3+c2]);
            p2_in[i*3+j] = $signed(m1_ff[r1*3+c2]) * $signed(m1_ff[r2*3+c1]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         cof[k] = p1_ff[k] - p2_ff[k];
      end
      adj3_in = '0;
      unique case (ord2_ff)
         2'd2: begin
            adj3_in[0] = ADJ_W'($signed(m2_ff[4]));
            adj3_in[1] = ADJ_W'(0) - ADJ_W'($signed(m2_ff[1]));
            adj3_in[3] = ADJ_W'(0) - ADJ_W'($signed(m2_ff[3]));
            adj3_in[4] = ADJ_W'($signed(m2_ff[0]));
         end
         2'd3: begin
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  adj3_in[j*3+i] = cof[i*3+j];
               end
            end
         end
         default: begin
            adj3_in[0] = ADJ_W'(1);
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo_in[i] = $signed(mc3_ff[i]) * $signed({1'b0, col3_ff[i][31:0]});
         hi_in[i] = $signed(mc3_ff[i]) * $signed(col3_ff[i][ADJ_W-1:32]);
      end
   end

   always_comb begin
      logic [DET_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         acc = acc + {hi_ff[i][ADJ_W-1], hi_ff[i], 32'd0}
                   + {{(DET_W-ADJ_W-1){lo_ff[i][ADJ_W]}}, lo_ff[i]};
      end
      unique case (ord4_ff)
         2'd2:    det_in = DET_W'($signed(det2_4_ff));
         2'd3:    det_in = acc;
         default: det_in = DET_W'($signed(m00_4_ff));
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      ord1_ff   <= ord_in;
      m1_ff     <= elem;
      ord2_ff   <= ord1_ff;
      m2_ff     <= m1_ff;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      ord3_ff   <= ord2_ff;
      adj3_ff   <= adj3_in;
      for (int i = 0; i < 3; i++) begin
         col3_ff[i] <= cof[i*3];
         mc3_ff[i]  <= m2_ff[i*3];
      end
      // bottom-right minor is m00*m11 - m01*m10, the order-two determinant
      det2_3_ff <= cof[8];
      ord4_ff   <= ord3_ff;
      adj4_ff   <= adj3_ff;
      det2_4_ff <= det2_3_ff;
      m00_4_ff  <= mc3_ff[0];
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      item5_ff.order <= ord4_ff;
      item5_ff.adj   <= adj4_ff;
      item5_ff.det   <= det_in;
   end

   assign push.valid = v5_ff;
   assign push.item  = item5_ff;

endmodule

// ----- design/smi_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_queue
// Short queue between front and back end, registered read port.
// ----------------------------------------------------------------------------
module smi_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  smi_pkg::smi_push_type push,
   output smi_pkg::smi_push_type pull,
   output logic                  pop
);
   import smi_pkg::*;

   smi_item_type      mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              out_valid_ff;
   smi_item_type      out_item_ff;

   assign pop = count_ff != '0;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.item;
      end
      if (pop) begin
         out_item_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_ff + QPTR_W'(push.valid);
         rd_ptr_ff    <= rd_ptr_ff + QPTR_W'(pop);
         count_ff     <= count_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
         out_valid_ff <= pop;
      end
   end

   assign pull.valid = out_valid_ff;
   assign pull.item  = out_item_ff;

endmodule

// ----- design/smi_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smi_back
// Rounds the determinant, classifies, divides the adjugate and formats.
// ----------------------------------------------------------------------------
module smi_back (
   input  logic                             clock,
   input  logic                             reset,
   input  smi_pkg::smi_push_type            pull,
   input  logic [smi_pkg::THR_W-1:0]        threshold,
   output logic                             valid,
   output logic [8:0][smi_pkg::ELEM_W-1:0]  q,
   output logic [smi_pkg::ELEM_W-1:0]       det_value,
   output smi_pkg::smi_status_type          status
);
   import smi_pkg::*;

   logic                   det_neg;
   logic [DET_W-1:0]       dmag_full;
   logic [MAG_W-1:0]       dmag, half, thr_sh;
   logic [DET_W-1:0]       rnd, dvmag;
   logic [ELEM_W-1:0]      dv;
   logic                   dv_sat;
   logic [8:0][NUM_W-1:0]  num_in, num_ff;
   logic [DEN_W-1:0]       den_ff;
   smi_side_type           side_in, side1_ff;
   smi_side_type           side_ff [0:LANE_LAT-1];
   logic [8:0][QUO_W-1:0]  quo;
   logic [8:0]             ovf;
   logic                   out_valid_ff;
   logic [8:0][ELEM_W-1:0] q_ff, q_in;
   logic [ELEM_W-1:0]      dv_ff;
   smi_status_type         status_ff, status_in;

   always_comb begin
      det_neg   = pull.item.det[DET_W-1];
      dmag_full = det_neg ? (DET_W'(0) - pull.item.det) : pull.item.det;
      dmag      = dmag_full[MAG_W-1:0];
      unique case (pull.item.order)
         2'd2: begin
            half   = MAG_W'(1) << (FRAC_BITS - 1);
            rnd    = DET_W'(dmag) + DET_W'(half);
            dvmag  = rnd >> FRAC_BITS;
            thr_sh = MAG_W'(threshold) << FRAC_BITS;
         end
         2'd3: begin
            half   = MAG_W'(1) << (2 * FRAC_BITS - 1);
            rnd    = DET_W'(dmag) + DET_W'(half);
            dvmag  = rnd >> (2 * FRAC_BITS);
            thr_sh = MAG_W'(threshold) << (2 * FRAC_BITS);
         end
         default: begin
            half   = '0;
            rnd    = DET_W'(dmag);
            dvmag  = rnd;
            thr_sh = MAG_W'(threshold);
         end
      endcase
      if (det_neg) begin
         dv_sat = dvmag > DET_W'(NEG_MAX);
         dv     = dv_sat ? NEG_MAX : ELEM_W'(0) - dvmag[ELEM_W-1:0];
      end else begin
         dv_sat = dvmag > DET_W'(POS_MAX);
         dv     = dv_sat ? POS_MAX : dvmag[ELEM_W-1:0];
      end

      side_in.valid       = pull.valid;
      side_in.order       = pull.item.order;
      side_in.det_value   = dv;
      side_in.det_sat     = dv_sat;
      side_in.zero_scalar = (pull.item.order == 2'd1) && (dmag == '0);
      side_in.singular    = (pull.item.order != 2'd1) && ((dmag == '0) || (dmag < thr_sh));
      for (int k = 0; k < 9; k++) begin
         logic [ADJ_W-1:0] a, amag;
         a    = pull.item.adj[k];
         amag = a[ADJ_W-1] ? (ADJ_W'(0) - a) : a;
         num_in[k]      = {1'b0, amag, {(2 * FRAC_BITS + 1){1'b0}}} + NUM_W'(dmag);
         side_in.neg[k] = a[ADJ_W-1] ^ det_neg;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= {dmag, 1'b0};
   end

   for (genvar k = 0; k < 9; k++) begin : g_lane
      smi_div_lane u_lane (
         .clock (clock),
         .num   (num_ff[k]),
         .den   (den_ff),
         .quo   (quo[k]),
         .ovf   (ovf[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff.valid <= 1'b0;
         for (int s = 0; s < LANE_LAT; s++) begin
            side_ff[s].valid <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         side1_ff.valid <= side_in.valid;
         side_ff[0].valid <= side1_ff.valid;
         for (int s = 1; s < LANE_LAT; s++) begin
            side_ff[s].valid <= side_ff[s-1].valid;
         end
         out_valid_ff <= side_ff[LANE_LAT-1].valid;
      end
      side1_ff.order       <= side_in.order;
      side1_ff.neg         <= side_in.neg;
      side1_ff.det_value   <= side_in.det_value;
      side1_ff.det_sat     <= side_in.det_sat;
      side1_ff.zero_scalar <= side_in.zero_scalar;
      side1_ff.singular    <= side_in.singular;
      side_ff[0].order       <= side1_ff.order;
      side_ff[0].neg         <= side1_ff.neg;
      side_ff[0].det_value   <= side1_ff.det_value;
      side_ff[0].det_sat     <= side1_ff.det_sat;
      side_ff[0].zero_scalar <= side1_ff.zero_scalar;
      side_ff[0].singular    <= side1_ff.singular;
      for (int s = 1; s < LANE_LAT; s++) begin
         side_ff[s].order       <= side_ff[s-1].order;
         side_ff[s].neg         <= side_ff[s-1].neg;
         side_ff[s].det_value   <= side_ff[s-1].det_value;
         side_ff[s].det_sat     <= side_ff[s-1].det_sat;
         side_ff[s].zero_scalar <= side_ff[s-1].zero_scalar;
         side_ff[s].singular    <= side_ff[s-1].singular;
      end
      q_ff      <= q_in;
      dv_ff     <= side_ff[LANE_LAT-1].det_value;
      status_ff <= status_in;
   end

   always_comb begin
      logic any_sat;
      smi_side_type sd;
      sd      = side_ff[LANE_LAT-1];
      any_sat = sd.det_sat;
      q_in    = '0;
      for (int k = 0; k < 9; k++) begin
         logic ng, es;
         ng = sd.neg[k] && (ovf[k] || (quo[k] != '0));
         if (ng) begin
            es = ovf[k] || (quo[k] > QUO_W'(NEG_MAX));
            q_in[k] = es ? NEG_MAX : ELEM_W'(0) - quo[k][ELEM_W-1:0];
         end else begin
            es = ovf[k] || (quo[k] > QUO_W'(POS_MAX));
            q_in[k] = es ? POS_MAX : quo[k][ELEM_W-1:0];
         end
         any_sat = any_sat | es;
      end
      priority if (sd.zero_scalar) begin
         q_in      = '0;
         q_in[0]   = POS_MAX;
         status_in = STAT_ZERO;
      end else if (sd.singular) begin
         q_in    = '0;
         q_in[0] = ONE_FIX;
         q_in[4] = ONE_FIX;
         if (sd.order == 2'd3) begin
            q_in[8] = ONE_FIX;
         end
         status_in = STAT_SINGULAR;
      end else begin
         status_in = any_sat ? STAT_SAT : STAT_OK;
      end
   end

   assign valid     = out_valid_ff;
   assign q         = q_ff;
   assign det_value = dv_ff;
   assign status    = status_ff;

endmodule

// ----- design/small_matrix_inverse_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_inverse_unit
// Determinant and inverse of a 1x1, 2x2 or 3x3 Q16.16 matrix per request.
// ----------------------------------------------------------------------------
// Path from the accepting edge to rsp_valid: 5 front stages, queue write
//   and registered read, 1 prep stage, 34 divider stages of one quotient
//   bit each, 1 output register.
// Throughput: one request per cycle; busy only rises if 8 requests sit
//   in the front end and queue together, which the free-running back end
//   never lets happen. The receiver cannot stall rsp_*.
// Reset: synchronous, clears all valid bits and credits; threshold = 1.
// ----------------------------------------------------------------------------
module small_matrix_inverse_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_size,
   input  logic [31:0] req_m00,
   input  logic [31:0] req_m01,
   input  logic [31:0] req_m02,
   input  logic [31:0] req_m10,
   input  logic [31:0] req_m11,
   input  logic [31:0] req_m12,
   input  logic [31:0] req_m20,
   input  logic [31:0] req_m21,
   input  logic [31:0] req_m22,
   // config: singular threshold
   input  logic        csr_write_enable,
   input  logic [30:0] csr_write_data,
   // result channel
   output logic        rsp_valid,
   output logic [31:0] rsp_q00,
   output logic [31:0] rsp_q01,
   output logic [31:0] rsp_q02,
   output logic [31:0] rsp_q10,
   output logic [31:0] rsp_q11,
   output logic [31:0] rsp_q12,
   output logic [31:0] rsp_q20,
   output logic [31:0] rsp_q21,
   output logic [31:0] rsp_q22,
   output logic [31:0] rsp_det_value,
   output logic [1:0]  rsp_status
);
   import smi_pkg::*;

   logic                   accept;
   logic [QCNT_W-1:0]      credit_ff;
   logic [THR_W-1:0]       thr_ff;
   logic [8:0][ELEM_W-1:0] elem;
   smi_push_type           push, pull;
   logic                   pop;
   logic [8:0][ELEM_W-1:0] q;
   smi_status_type         status;

   // Credits count requests in the front end plus those waiting in the
   // queue; a request only enters when a queue slot is guaranteed.
   assign busy   = credit_ff == QCNT_W'(QUEUE_DEPTH);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         thr_ff    <= THR_W'(1);
      end else begin
         credit_ff <= credit_ff + QCNT_W'(accept) - QCNT_W'(pop);
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
      end
   end

   assign elem = {req_m22, req_m21, req_m20, req_m12, req_m11, req_m10,
                  req_m02, req_m01, req_m00};

   // front end: order clamp, minors, adjugate, determinant
   smi_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .size   (req_size),
      .elem   (elem),
      .push   (push)
   );

   // decoupling queue
   smi_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pull  (pull),
      .pop   (pop)
   );

   // back end: classify, divide, saturate
   smi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pull      (pull),
      .threshold (thr_ff),
      .valid     (rsp_valid),
      .q         (q),
      .det_value (rsp_det_value),
      .status    (status)
   );

   assign rsp_q00    = q[0];
   assign rsp_q01    = q[1];
   assign rsp_q02    = q[2];
   assign rsp_q10    = q[3];
   assign rsp_q11    = q[4];
   assign rsp_q12    = q[5];
   assign rsp_q20    = q[6];
   assign rsp_q21    = q[7];
   assign rsp_q22    = q[8];
   assign rsp_status = status;

   // credits never exceed queue depth
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("credit overflow");

   // a queue pop always has a credit behind it
   a_pop_credit: assert property (@(posedge clock) disable iff (reset)
      pop |-> credit_ff != '0)
      else $error("pop without credit");

   // zero scalar returns the largest positive reciprocal and zero determinant
   a_zero_scalar: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_ZERO) |->
         (rsp_q00 == POS_MAX && rsp_det_value == '0 && rsp_q11 == '0))
      else $error("bad zero scalar result");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for small_matrix_inverse_unit. A directed table
// covers the extremes and the special cases. Random matrices follow,
// run under several singular thresholds. Each request but a typed table row is
// scored against an exact wide-integer predictor of the determinant and the inverse.
// ----------------------------------------------------------------------------
module tb;
   import smi_pkg::*;

   typedef logic [127:0] wide_u;
   typedef logic signed [127:0] wide_s;

   // one matrix request and one inverse response
   typedef struct packed {
      logic [1:0]        size;
      logic [8:0][31:0]  m;
   } matrix_req_t;

   typedef struct packed {
      logic [8:0][31:0]  q;
      logic [31:0]       det;
      logic [1:0]        status;
   } inverse_rsp_t;

   typedef struct {
      matrix_req_t  req;
      bit           typed;      // expected response typed in below
      inverse_rsp_t rsp;
   } dir_row_t;

   localparam int N_PHASE     = 6;
   localparam int PHASE_ITEMS = 100;
   localparam int IDLE_LIMIT  = 3000;
   localparam int DRAIN_WAIT  = 60;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   matrix_req_t req;
   logic        csr_write_enable;
   logic [30:0] csr_write_data;
   logic        rsp_valid;
   inverse_rsp_t rsp_act;
   logic [31:0] rsp_q [9];
   logic [31:0] rsp_det_value;
   logic [1:0]  rsp_status;

   inverse_rsp_t inverse_fifo [$];
   logic [30:0]  thr_shadow;
   int           errors;
   int           idle_cycles;

   small_matrix_inverse_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_size         (req.size),
      .req_m00          (req.m[0]),
      .req_m01          (req.m[1]),
      .req_m02          (req.m[2]),
      .req_m10          (req.m[3]),
      .req_m11          (req.m[4]),
      .req_m12          (req.m[5]),
      .req_m20          (req.m[6]),
      .req_m21          (req.m[7]),
      .req_m22          (req.m[8]),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_q00          (rsp_q[0]),
      .rsp_q01          (rsp_q[1]),
      .rsp_q02          (rsp_q[2]),
      .rsp_q10          (rsp_q[3]),
      .rsp_q11          (rsp_q[4]),
      .rsp_q12          (rsp_q[5]),
      .rsp_q20          (rsp_q[6]),
      .rsp_q21          (rsp_q[7]),
      .rsp_q22          (rsp_q[8]),
      .rsp_det_value    (rsp_det_value),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sign and magnitude to saturated 32-bit raw value
   function automatic logic [31:0] clamp32(input bit neg, input wide_u mag, inout bit sat);
      wide_u t;
      if (neg) begin
         if (mag > wide_u'(32'h8000_0000)) begin
            sat = 1'b1;
            return NEG_MAX;
         end
         t = -mag;
         return t[31:0];
      end
      if (mag > wide_u'(32'h7FFF_FFFF)) begin
         sat = 1'b1;
         return POS_MAX;
      end
      return mag[31:0];
   endfunction

   // exact determinant and adjugate, rounding only at the end
   function automatic inverse_rsp_t predict_inverse(input matrix_req_t r, input logic [30:0] thr);
      inverse_rsp_t o;
      longint  m [3][3];
      longint  adj [3][3];
      longint  d2;
      wide_s   det, pa, pb;
      wide_u   dmag, half, num, qm;
      logic [63:0] a64;
      int      n, sh, r1, r2, c1, c2;
      bit      sat, dneg, neg;
      o = '0;
      sat = 1'b0;
      n = (r.size == 2'd0) ? 1 : int'(r.size);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            m[i][j] = longint'($signed(r.m[i*3+j]));
            adj[i][j] = 0;
         end
      if (n == 1) begin
         adj[0][0] = 1;
         det = m[0][0];
      end else if (n == 2) begin
         adj[0][0] = m[1][1];
         adj[0][1] = -m[0][1];
         adj[1][0] = -m[1][0];
         adj[1][1] = m[0][0];
         d2 = m[0][0] * m[1][1] - m[0][1] * m[1][0];   // wraps at 64 bits
         det = d2;
      end else begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               r1 = (i + 1) % 3; r2 = (i + 2) % 3;
               c1 = (j + 1) % 3; c2 = (j + 2) % 3;
               adj[j][i] = m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
            end
         det = '0;
         for (int i = 0; i < 3; i++) begin
            pa = m[i][0];
            pb = adj[0][i];
            det = det + pa * pb;
         end
      end
      sh   = (n - 1) * FRAC_BITS;
      dneg = det[127];
      dmag = dneg ? wide_u'(-det) : wide_u'(det);
      half = (sh != 0) ? (wide_u'(1) << (sh - 1)) : '0;
      o.det = clamp32(dneg, (dmag + half) >> sh, sat);
      if (n == 1 && dmag == '0) begin
         o.q[0] = POS_MAX;
         o.status = STAT_ZERO;
      end else if (n >= 2 && (dmag == '0 || dmag < (wide_u'(thr) << sh))) begin
         for (int i = 0; i < n; i++) o.q[i*3+i] = ONE_FIX;
         o.status = STAT_SINGULAR;
      end else begin
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
               a64 = adj[i][j];
               if (adj[i][j] < 0) a64 = -a64;
               num = wide_u'(a64) << (2 * FRAC_BITS);
               qm  = ((num << 1) + dmag) / (dmag << 1);
               neg = (adj[i][j] < 0) != dneg;
               o.q[i*3+j] = clamp32(neg && qm != '0, qm, sat);
            end
         o.status = sat ? STAT_SAT : STAT_OK;
      end
      return o;
   endfunction

   function automatic logic [31:0] rand_elem();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2, 3:    return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);  // +-4.0
         4:       return 32'($urandom_range(0, 1 << 13)) - 32'(1 << 12);  // tiny
         default: begin
            case ($urandom_range(0, 5))
               0:       return '0;
               1:       return 32'd1;
               2:       return '1;
               3:       return POS_MAX;
               4:       return NEG_MAX;
               default: return ONE_FIX;
            endcase
         end
      endcase
   endfunction

   function automatic matrix_req_t rand_matrix();
      matrix_req_t r;
      r.size = 2'($urandom_range(0, 3));
      for (int k = 0; k < 9; k++) r.m[k] = rand_elem();
      // near singular: row 1 tracks row 0 with a little noise
      if ($urandom_range(0, 3) == 0)
         for (int k = 0; k < 3; k++)
            r.m[3+k] = r.m[k] + 32'($urandom_range(0, 8)) - 32'd4;
      return r;
   endfunction

   function automatic matrix_req_t mk_req(input logic [1:0] sz, input logic [31:0] fill,
                                          input logic [31:0] diag);
      matrix_req_t r;
      r.size = sz;
      for (int k = 0; k < 9; k++) r.m[k] = (k % 4 == 0) ? diag : fill;
      return r;
   endfunction

   function automatic inverse_rsp_t identity_rsp(input int n, input logic [31:0] det,
                                                 input logic [1:0] st);
      inverse_rsp_t o;
      o = '0;
      for (int i = 0; i < n; i++) o.q[i*3+i] = ONE_FIX;
      o.det = det;
      o.status = st;
      return o;
   endfunction

   // hold the request until accepted; start stays high on return
   task automatic send_request(input matrix_req_t r);
      start <= 1'b1;
      req   <= r;
      do @(posedge clock); while (busy);
      inverse_fifo.push_back(predict_inverse(r, thr_shadow));
   endtask

   task automatic send_typed(input matrix_req_t r, input inverse_rsp_t e);
      start <= 1'b1;
      req   <= r;
      do @(posedge clock); while (busy);
      inverse_fifo.push_back(e);
   endtask

   task automatic idle_gap();
      int g;
      if ($urandom_range(0, 9) < 6) return;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (g) @(posedge clock);
   endtask

   // drain, then settle the pipe before touching the threshold
   task automatic drain();
      start <= 1'b0;
      while (inverse_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [30:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      thr_shadow = v;
   endtask

   // response checker and watchdog
   always @(posedge clock) begin
      inverse_rsp_t e;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
         if (rsp_valid) begin
            for (int k = 0; k < 9; k++) rsp_act.q[k] = rsp_q[k];
            rsp_act.det    = rsp_det_value;
            rsp_act.status = rsp_status;
            if (inverse_fifo.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response %h", rsp_act);
            end else begin
               e = inverse_fifo.pop_front();
               if (e !== rsp_act) begin
                  errors++;
                  if (errors <= 10) begin
                     for (int k = 0; k < 9; k++)
                        if (e.q[k] !== rsp_act.q[k])
                           $display("q[%0d] exp %h got %h", k, e.q[k], rsp_act.q[k]);
                     if (e.det !== rsp_act.det)
                        $display("det exp %h got %h", e.det, rsp_act.det);
                     if (e.status !== rsp_act.status)
                        $display("status exp %0d got %0d", e.status, rsp_act.status);
                  end
               end
            end
         end
      end
   end

   initial begin
      dir_row_t    rows [$];
      dir_row_t    row;
      matrix_req_t r;
      logic [30:0] thr_plan [N_PHASE];
      errors      = 0;
      idle_cycles = 0;
      thr_shadow  = 31'd1;
      reset            <= 1'b1;
      start            <= 1'b0;
      req              <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; typed rows are readable at a glance
      row.typed = 1'b1;
      row.req = mk_req(2'd3, 32'd0, ONE_FIX);
      row.rsp = identity_rsp(3, ONE_FIX, STAT_OK);              rows.push_back(row);
      row.req = mk_req(2'd2, 32'd0, ONE_FIX);
      row.rsp = identity_rsp(2, ONE_FIX, STAT_OK);              rows.push_back(row);
      row.req = mk_req(2'd1, 32'hDEAD_BEEF, ONE_FIX);
      row.rsp = identity_rsp(1, ONE_FIX, STAT_OK);              rows.push_back(row);
      row.req = mk_req(2'd1, '1, 32'd0);                         // zero scalar
      row.rsp = '0; row.rsp.q[0] = POS_MAX; row.rsp.status = STAT_ZERO;
      rows.push_back(row);
      row.req = mk_req(2'd2, 32'd0, 32'd0);                      // all zero: singular
      row.rsp = identity_rsp(2, 32'd0, STAT_SINGULAR);          rows.push_back(row);
      row.req = mk_req(2'd3, 32'd0, 32'd0);
      row.rsp = identity_rsp(3, 32'd0, STAT_SINGULAR);          rows.push_back(row);
      row.typed = 1'b0;
      row.req = mk_req(2'd0, 32'd5, 32'h0002_0000);  rows.push_back(row);   // size zero
      row.req = mk_req(2'd1, 32'd0, 32'd1);          rows.push_back(row);   // reciprocal saturates
      row.req = mk_req(2'd1, 32'd0, '1);             rows.push_back(row);
      row.req = mk_req(2'd1, 32'd0, POS_MAX);        rows.push_back(row);
      row.req = mk_req(2'd1, 32'd0, NEG_MAX);        rows.push_back(row);
      row.req = mk_req(2'd2, POS_MAX, POS_MAX);      rows.push_back(row);
      row.req = mk_req(2'd2, NEG_MAX, NEG_MAX);      rows.push_back(row);
      row.req = mk_req(2'd2, POS_MAX, NEG_MAX);      rows.push_back(row);
      row.req = mk_req(2'd3, NEG_MAX, NEG_MAX);      rows.push_back(row);
      row.req = mk_req(2'd3, POS_MAX, NEG_MAX);      rows.push_back(row);
      row.req = mk_req(2'd3, NEG_MAX, POS_MAX);      rows.push_back(row);
      row.req = mk_req(2'd3, 32'h0000_8000, 32'h0003_0000); rows.push_back(row);
      row.req = mk_req(2'd2, 32'd0, 32'd255);        rows.push_back(row);   // det below threshold
      row.req = mk_req(2'd2, 32'd0, 32'd256);        rows.push_back(row);   // det at threshold
      row.req = mk_req(2'd3, 32'd0, 32'h0000_0200);  rows.push_back(row);
      row.req = mk_req(2'd3, ONE_FIX, ONE_FIX);      rows.push_back(row);   // rank one
      row.req = mk_req(2'd3, 32'hFFFF_0000, 32'h0002_0000); rows.push_back(row);
      foreach (rows[i]) begin
         if (rows[i].typed) send_typed(rows[i].req, rows[i].rsp);
         else send_request(rows[i].req);
         idle_gap();
      end
      drain();   // sender holds off until every response is back

      thr_plan[0] = 31'd1;
      thr_plan[1] = 31'd0;
      thr_plan[2] = 31'h7FFF_FFFF;
      thr_plan[3] = 31'h0001_0000;
      thr_plan[4] = 31'($urandom);
      thr_plan[5] = 31'd1;
      for (int p = 0; p < N_PHASE; p++) begin
         if (p != 0) begin
            drain();
            write_threshold(thr_plan[p]);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = rand_matrix();
            send_request(r);
            idle_gap();
         end
      end

      drain();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/smi_pkg.sv
design/smi_div_lane.sv
design/smi_front.sv
design/smi_queue.sv
design/smi_back.sv
design/small_matrix_inverse_unit.sv
test/tb.sv
